// ===== design/dmpi_pkg.sv =====
// shared types, constants and control store for the dual-joint current loop
package dmpi_pkg;

    // joint count of the integrator store; the ports carry two joints
    localparam int JOINTS = 2;
    localparam int ACTIVE = (JOINTS < 2) ? JOINTS : 2;
    localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // control store geometry
    localparam int PC_W      = 4;
    localparam int UCODE_LEN = 12;

    // datapath widths
    localparam int OPA_W   = 19;
    localparam int OPB_W   = 18;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 54;
    localparam int MAG_W   = 36;
    localparam int CHUNK_W = MAG_W / 2;
    localparam int RND_SH  = 20;
    localparam int FF_SH   = 3;

    // 15*2048*16 + rounding + offset that keeps the ADC term positive
    localparam logic [19:0] ADC_BIAS = 20'd1015816;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEGRAL_GAIN = 3'd1,
        CFG_INTEG_LIMIT   = 3'd2,
        CFG_DUTY_LIMIT    = 3'd3,
        CFG_RESISTANCE    = 3'd4,
        CFG_TORQUE_CONST  = 3'd5,
        CFG_INV_SUPPLY    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRE,
        OP_MUL,
        OP_ABS,
        OP_FIN,
        OP_PUB
    } t_op;

    typedef enum logic [2:0] {
        A_RES,
        A_KT,
        A_KP,
        A_KI,
        A_MAGLO,
        A_MAGHI
    } t_asel;

    typedef enum logic [2:0] {
        B_TARGET,
        B_SPEED,
        B_ERR,
        B_INTEG,
        B_INV
    } t_bsel;

    typedef enum logic [1:0] {
        SH_0,
        SH_FF,
        SH_CHUNK
    } t_shift;

    typedef enum logic {
        J_NEXT,
        J_JOINT
    } t_jmp;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_op              op;
        t_asel            asel;
        t_bsel            bsel;
        t_shift           shift;
        logic             load;
        t_jmp             jmp;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic             run;
        logic             pub;
        logic [JW-1:0]    joint;
        t_uword           uw;
    } t_seq;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
        logic [14:0] integrator_limit;
        logic [15:0] duty_limit;
        logic [15:0] winding_resistance;
        logic [15:0] torque_constant;
        logic [15:0] inverse_supply;
    } t_cfg;

    typedef struct packed {
        logic        [15:0] adc_a;
        logic        [15:0] adc_b;
        logic signed [15:0] speed_a;
        logic signed [15:0] speed_b;
        logic signed [15:0] target_a;
        logic signed [15:0] target_b;
    } t_item;

    typedef struct packed {
        logic        [15:0] duty_a;
        logic               reverse_a;
        logic        [15:0] duty_b;
        logic               reverse_b;
        logic signed [15:0] sensed_a;
        logic signed [15:0] sensed_b;
    } t_result;

    // per-joint program; the last joint step loops back for the next joint
    function automatic t_uword dmpi_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, asel: A_RES, bsel: B_TARGET, shift: SH_0,
              load: 1'b0, jmp: J_NEXT, target: '0};
        case (pc)
            4'd0: begin
                w.op = OP_PRE;
            end
            4'd1: begin
                w.op = OP_MUL; w.asel = A_RES; w.bsel = B_TARGET; w.load = 1'b1;
            end
            4'd2: begin
                w.op = OP_MUL; w.asel = A_KT; w.bsel = B_SPEED; w.shift = SH_FF;
            end
            4'd3: begin
                w.op = OP_MUL; w.asel = A_KP; w.bsel = B_ERR;
            end
            4'd4: begin
                w.op = OP_MUL; w.asel = A_KI; w.bsel = B_INTEG;
            end
            4'd5: begin
                w.op = OP_NOP;
            end
            4'd6: begin
                w.op = OP_ABS;
            end
            4'd7: begin
                w.op = OP_MUL; w.asel = A_MAGLO; w.bsel = B_INV; w.load = 1'b1;
            end
            4'd8: begin
                w.op = OP_MUL; w.asel = A_MAGHI; w.bsel = B_INV; w.shift = SH_CHUNK;
            end
            4'd9: begin
                w.op = OP_NOP;
            end
            4'd10: begin
                w.op = OP_FIN; w.jmp = J_JOINT; w.target = 4'd0;
            end
            4'd11: begin
                w.op = OP_PUB;
            end
            default: begin
                w.op = OP_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/dmpi_ctrl.sv =====
// microcode sequencer: step counter, joint counter and control store
module dmpi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_slot_free,
    output logic             o_in_ready,
    output dmpi_pkg::t_seq   o_seq
);

    dmpi_pkg::t_seq_state            r_state, n_state;
    logic [dmpi_pkg::PC_W-1:0]       r_pc, n_pc;
    logic [dmpi_pkg::JW-1:0]         r_joint, n_joint;
    dmpi_pkg::t_uword                w_uw;
    logic                            w_last;
    logic                            w_pub_step;

    assign w_uw       = dmpi_pkg::dmpi_ucode(r_pc);
    assign w_last     = (r_joint == dmpi_pkg::JW'(dmpi_pkg::ACTIVE - 1));
    assign w_pub_step = (w_uw.op == dmpi_pkg::OP_PUB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmpi_pkg::SEQ_IDLE;
            r_pc    <= '0;
            r_joint <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_joint <= n_joint;
        end
    end

    // next state, step and joint
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_joint = r_joint;
        case (r_state)
            dmpi_pkg::SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = dmpi_pkg::SEQ_RUN;
                    n_pc    = '0;
                    n_joint = '0;
                end
            end
            dmpi_pkg::SEQ_RUN: begin
                if (w_pub_step) begin
                    if (i_slot_free) begin
                        n_state = dmpi_pkg::SEQ_IDLE;
                    end
                end else if (w_uw.jmp == dmpi_pkg::J_JOINT && !w_last) begin
                    n_pc    = w_uw.target;
                    n_joint = r_joint + dmpi_pkg::JW'(1);
                end else begin
                    n_pc = r_pc + dmpi_pkg::PC_W'(1);
                end
            end
            default: begin
                n_state = dmpi_pkg::SEQ_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_seq.run   = 1'b0;
        o_seq.pub   = 1'b0;
        o_seq.joint = r_joint;
        o_seq.uw    = w_uw;
        case (r_state)
            dmpi_pkg::SEQ_IDLE: begin
                o_in_ready = 1'b1;
            end
            dmpi_pkg::SEQ_RUN: begin
                o_seq.run = !w_pub_step;
                o_seq.pub = w_pub_step && i_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=>
            (r_state == dmpi_pkg::SEQ_RUN && r_pc == '0 && r_joint == '0))
        else $error("sequencer did not restart at step zero of joint zero");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmpi_pkg::SEQ_RUN) |->
            (r_pc <= dmpi_pkg::PC_W'(dmpi_pkg::UCODE_LEN - 1) &&
             r_joint <= dmpi_pkg::JW'(dmpi_pkg::ACTIVE - 1)))
        else $error("step or joint counter out of range");

endmodule

// ===== design/dmpi_dp.sv =====
// datapath: sense conversion, integrator, shared multiplier and accumulator
module dmpi_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmpi_pkg::t_seq     i_seq,
    input  dmpi_pkg::t_cfg     i_cfg,
    input  dmpi_pkg::t_item    i_item,
    output dmpi_pkg::t_result  o_result
);

    logic signed [15:0]                 r_integ [dmpi_pkg::JOINTS];
    logic signed [16:0]                 r_err;
    logic signed [15:0]                 r_ival;
    logic signed [dmpi_pkg::PROD_W-1:0] r_prod;
    logic                               r_pvalid;
    dmpi_pkg::t_shift                   r_pshift;
    logic                               r_pload;
    logic signed [dmpi_pkg::ACC_W-1:0]  r_acc;
    logic [dmpi_pkg::MAG_W-1:0]         r_mag;
    logic                               r_neg;
    logic [15:0]                        r_duty   [2];
    logic                               r_rev    [2];
    logic signed [15:0]                 r_sensed [2];

    logic                               w_sel_b;
    logic [15:0]                        w_adc;
    logic signed [15:0]                 w_speed;
    logic signed [15:0]                 w_tgt;
    logic [19:0]                        w_adc15;
    logic [19:0]                        w_biased;
    logic signed [15:0]                 w_meas;
    logic signed [16:0]                 w_err;
    logic signed [17:0]                 w_sum;
    logic signed [17:0]                 w_lim;
    logic signed [17:0]                 w_clamp;
    logic signed [dmpi_pkg::OPA_W-1:0]  w_opa;
    logic signed [dmpi_pkg::OPB_W-1:0]  w_opb;
    logic signed [dmpi_pkg::PROD_W-1:0] w_prod;
    logic signed [dmpi_pkg::ACC_W-1:0]  w_pext;
    logic signed [dmpi_pkg::ACC_W-1:0]  w_pshifted;
    logic signed [dmpi_pkg::ACC_W-1:0]  w_abs;
    logic [dmpi_pkg::ACC_W-1:0]         w_rnd;
    logic [dmpi_pkg::ACC_W-dmpi_pkg::RND_SH-1:0] w_dmag;
    logic [15:0]                        w_duty;
    logic                               w_rev;
    logic                               w_pre;

    assign w_sel_b = (i_seq.joint != '0);
    assign w_adc   = w_sel_b ? i_item.adc_b    : i_item.adc_a;
    assign w_speed = w_sel_b ? i_item.speed_b  : i_item.speed_a;
    assign w_tgt   = w_sel_b ? i_item.target_b : i_item.target_a;
    assign w_pre   = i_seq.run && (i_seq.uw.op == dmpi_pkg::OP_PRE);

    // sensed = ((bias - 15*adc) >> 4) - 32768, the subtract is an msb flip
    assign w_adc15  = {w_adc, 4'b0000} - {4'b0000, w_adc};
    assign w_biased = dmpi_pkg::ADC_BIAS - w_adc15;
    assign w_meas   = {~w_biased[19], w_biased[18:4]};
    assign w_err    = {w_tgt[15], w_tgt} - {w_meas[15], w_meas};

    // anti-windup clamp
    assign w_sum = {{2{r_integ[i_seq.joint][15]}}, r_integ[i_seq.joint]}
                 + {w_err[16], w_err};
    assign w_lim = {3'b000, i_cfg.integrator_limit};

    always_comb begin
        if (w_sum > w_lim) begin
            w_clamp = w_lim;
        end else if (w_sum < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_sum;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (i_seq.uw.asel)
            dmpi_pkg::A_RES:   w_opa = {3'b000, i_cfg.winding_resistance};
            dmpi_pkg::A_KT:    w_opa = {3'b000, i_cfg.torque_constant};
            dmpi_pkg::A_KP:    w_opa = {3'b000, i_cfg.prop_gain};
            dmpi_pkg::A_KI:    w_opa = {3'b000, i_cfg.integral_gain};
            dmpi_pkg::A_MAGLO: w_opa = {1'b0, r_mag[dmpi_pkg::CHUNK_W-1:0]};
            dmpi_pkg::A_MAGHI: w_opa = {1'b0, r_mag[dmpi_pkg::MAG_W-1:dmpi_pkg::CHUNK_W]};
            default:           w_opa = '0;
        endcase
    end

    always_comb begin
        case (i_seq.uw.bsel)
            dmpi_pkg::B_TARGET: w_opb = {{2{w_tgt[15]}}, w_tgt};
            dmpi_pkg::B_SPEED:  w_opb = {{2{w_speed[15]}}, w_speed};
            dmpi_pkg::B_ERR:    w_opb = {r_err[16], r_err};
            dmpi_pkg::B_INTEG:  w_opb = {{2{r_ival[15]}}, r_ival};
            dmpi_pkg::B_INV:    w_opb = {2'b00, i_cfg.inverse_supply};
            default:            w_opb = '0;
        endcase
    end

    assign w_prod = w_opa * w_opb;

    assign w_pext = {{(dmpi_pkg::ACC_W - dmpi_pkg::PROD_W){r_prod[dmpi_pkg::PROD_W-1]}},
                     r_prod};

    always_comb begin
        case (r_pshift)
            dmpi_pkg::SH_0:     w_pshifted = w_pext;
            dmpi_pkg::SH_FF:    w_pshifted = w_pext <<< dmpi_pkg::FF_SH;
            dmpi_pkg::SH_CHUNK: w_pshifted = w_pext <<< dmpi_pkg::CHUNK_W;
            default:            w_pshifted = w_pext;
        endcase
    end

    assign w_abs = r_acc[dmpi_pkg::ACC_W-1] ? -r_acc : r_acc;

    // round half up to Q1.15, then saturate at the duty limit
    assign w_rnd  = r_acc + (dmpi_pkg::ACC_W'(1) << (dmpi_pkg::RND_SH - 1));
    assign w_dmag = w_rnd[dmpi_pkg::ACC_W-1:dmpi_pkg::RND_SH];
    assign w_duty = (w_dmag > {{(dmpi_pkg::ACC_W - dmpi_pkg::RND_SH - 16){1'b0}},
                               i_cfg.duty_limit})
                  ? i_cfg.duty_limit : w_dmag[15:0];
    assign w_rev  = r_neg && (i_cfg.inverse_supply != '0) && (i_cfg.duty_limit != '0);

    // integrator state and product pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < dmpi_pkg::JOINTS; j++) begin
                r_integ[j] <= '0;
            end
            r_pvalid <= 1'b0;
        end else begin
            if (w_pre) begin
                r_integ[i_seq.joint] <= w_clamp[15:0];
            end
            r_pvalid <= i_seq.run && (i_seq.uw.op == dmpi_pkg::OP_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pre) begin
            r_err              <= w_err;
            r_ival             <= w_clamp[15:0];
            r_sensed[w_sel_b]  <= w_meas;
        end
        if (i_seq.run && i_seq.uw.op == dmpi_pkg::OP_MUL) begin
            r_prod   <= w_prod;
            r_pshift <= i_seq.uw.shift;
            r_pload  <= i_seq.uw.load;
        end
        if (r_pvalid) begin
            r_acc <= (r_pload ? '0 : r_acc) + w_pshifted;
        end
        if (i_seq.run && i_seq.uw.op == dmpi_pkg::OP_ABS) begin
            r_mag <= w_abs[dmpi_pkg::MAG_W-1:0];
            r_neg <= r_acc[dmpi_pkg::ACC_W-1];
        end
        if (i_seq.run && i_seq.uw.op == dmpi_pkg::OP_FIN) begin
            r_duty[w_sel_b] <= w_duty;
            r_rev[w_sel_b]  <= w_rev;
        end
    end

    assign o_result.duty_a    = r_duty[0];
    assign o_result.reverse_a = r_rev[0];
    assign o_result.sensed_a  = r_sensed[0];
    assign o_result.duty_b    = (dmpi_pkg::ACTIVE > 1) ? r_duty[1]   : '0;
    assign o_result.reverse_b = (dmpi_pkg::ACTIVE > 1) ? r_rev[1]    : 1'b0;
    assign o_result.sensed_b  = (dmpi_pkg::ACTIVE > 1) ? r_sensed[1] : '0;

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pre |=> (($signed({2'b00, r_ival}) <= $signed({3'b000, i_cfg.integrator_limit})) ||
                   r_ival[15]) &&
                  (!r_ival[15] ||
                   ($signed({{2{r_ival[15]}}, r_ival}) >=
                    -$signed({3'b000, i_cfg.integrator_limit}))))
        else $error("integrator left the anti-windup bound");

endmodule

// ===== design/dual_motor_pi_current_loop.sv =====
// top level of the dual-joint pi current loop with feedforward and anti-windup
//
// Each request carries, for joints a and b, a raw current-sense word, a
// velocity and a target current, and yields one result with the measured
// current (Q5.11), the duty magnitude (Q1.15, saturated at duty_limit) and a
// reverse bit per joint. Between one input acceptance and the next, the
// sequencer passes through an idle state in which o_in_ready is high, then an
// 11-step microprogram per joint (conversion and integrator update, four
// voltage products, magnitude, two duty partial products, round and
// saturate) on a single shared 19x18 multiplier, plus one step that moves the
// result into the output register. The output register lets the next request
// be accepted while a result still waits for i_out_ready; the sequencer only
// waits at its final step if the previous result has not been taken yet.
// Configuration writes take effect at once and are meant to happen while the
// block is idle; an unknown register index is ignored. The integrators reset
// to zero.
module dual_motor_pi_current_loop (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,

    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [15:0] i_adc_a,
    input  logic        [15:0] i_adc_b,
    input  logic signed [15:0] i_speed_a,
    input  logic signed [15:0] i_speed_b,
    input  logic signed [15:0] i_target_a,
    input  logic signed [15:0] i_target_b,

    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [15:0] o_duty_a,
    output logic               o_reverse_a,
    output logic        [15:0] o_duty_b,
    output logic               o_reverse_b,
    output logic signed [15:0] o_sensed_a,
    output logic signed [15:0] o_sensed_b
);

    dmpi_pkg::t_cfg     r_cfg;
    dmpi_pkg::t_item    r_item;
    dmpi_pkg::t_result  r_out;
    logic               r_out_valid;

    dmpi_pkg::t_seq     w_seq;
    dmpi_pkg::t_result  w_result;
    logic               w_slot_free;
    logic               w_accept;

    // output slot can take a new result when empty or being drained
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain          <= 16'd1024;
            r_cfg.integral_gain      <= 16'd102;
            r_cfg.integrator_limit   <= 15'd6144;
            r_cfg.duty_limit         <= 16'd0;
            r_cfg.winding_resistance <= 16'd512;
            r_cfg.torque_constant    <= 16'd46;
            r_cfg.inverse_supply     <= 16'd5461;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dmpi_pkg::CFG_PROP_GAIN:     r_cfg.prop_gain          <= i_cfg_data;
                dmpi_pkg::CFG_INTEGRAL_GAIN: r_cfg.integral_gain      <= i_cfg_data;
                dmpi_pkg::CFG_INTEG_LIMIT:   r_cfg.integrator_limit   <= i_cfg_data[14:0];
                dmpi_pkg::CFG_DUTY_LIMIT:    r_cfg.duty_limit         <= i_cfg_data;
                dmpi_pkg::CFG_RESISTANCE:    r_cfg.winding_resistance <= i_cfg_data;
                dmpi_pkg::CFG_TORQUE_CONST:  r_cfg.torque_constant    <= i_cfg_data;
                dmpi_pkg::CFG_INV_SUPPLY:    r_cfg.inverse_supply     <= i_cfg_data;
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // request capture, held for the whole program
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.adc_a    <= i_adc_a;
            r_item.adc_b    <= i_adc_b;
            r_item.speed_a  <= i_speed_a;
            r_item.speed_b  <= i_speed_b;
            r_item.target_a <= i_target_a;
            r_item.target_b <= i_target_b;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq.pub) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.pub) begin
            r_out <= w_result;
        end
    end

    dmpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_slot_free (w_slot_free),
        .o_in_ready  (o_in_ready),
        .o_seq       (w_seq)
    );

    dmpi_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seq    (w_seq),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_duty_a    = r_out.duty_a;
    assign o_reverse_a = r_out.reverse_a;
    assign o_duty_b    = r_out.duty_b;
    assign o_reverse_b = r_out.reverse_b;
    assign o_sensed_a  = r_out.sensed_a;
    assign o_sensed_b  = r_out.sensed_b;

    // a publish only happens into a free slot, and the sequencer is idle after it
    a_pub_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq.pub |-> (w_slot_free && !w_accept))
        else $error("result published over an untaken result");

    a_idle_after_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq.pub |=> (o_in_ready && r_out_valid))
        else $error("sequencer not idle after publishing a result");

endmodule

// ===== verif/tb_dual_motor_pi_current_loop.sv =====
// self-checking testbench for the dual-joint pi current loop with feedforward and anti-windup
`timescale 1ns / 1ps

module tb_dual_motor_pi_current_loop;

    // no-handshake watchdog, generous against the request time plus stalls
    localparam int STALL_LIMIT  = 2000;
    // quiet time after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_REQS    = 142;
    // index 7 is not a register and must be ignored
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_REQ_KNOWN,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind         kind;
        dmpi_pkg::t_item    item;
        dmpi_pkg::t_result  known;
        logic [2:0]         idx;
        logic [15:0]        data;
    } t_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    dmpi_pkg::t_item    req_item;
    logic               o_out_valid;
    logic               i_out_ready;
    dmpi_pkg::t_result  got;

    // predictor copy of the register file and the per-joint integrators
    logic [15:0] gain_p, gain_i, duty_cap, res_ff, kt_ff, inv_vsup;
    logic [14:0] integ_bound;
    int          integ [2];

    dmpi_pkg::t_result  tick_outcomes_q [$];
    t_step              plan [$];
    logic               calm;
    int                 n_errors, n_reqs, n_checked, n_writes, idle_count;

    dual_motor_pi_current_loop dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_adc_a     (req_item.adc_a),
        .i_adc_b     (req_item.adc_b),
        .i_speed_a   (req_item.speed_a),
        .i_speed_b   (req_item.speed_b),
        .i_target_a  (req_item.target_a),
        .i_target_b  (req_item.target_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_duty_a    (got.duty_a),
        .o_reverse_a (got.reverse_a),
        .o_duty_b    (got.duty_b),
        .o_reverse_b (got.reverse_b),
        .o_sensed_a  (got.sensed_a),
        .o_sensed_b  (got.sensed_b)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            dmpi_pkg::CFG_PROP_GAIN:     gain_p      = data;
            dmpi_pkg::CFG_INTEGRAL_GAIN: gain_i      = data;
            dmpi_pkg::CFG_INTEG_LIMIT:   integ_bound = data[14:0];  // top bit dropped
            dmpi_pkg::CFG_DUTY_LIMIT:    duty_cap    = data;
            dmpi_pkg::CFG_RESISTANCE:    res_ff      = data;
            dmpi_pkg::CFG_TORQUE_CONST:  kt_ff       = data;
            dmpi_pkg::CFG_INV_SUPPLY:    inv_vsup    = data;
            default: ;                                    // unknown index, ignored
        endcase
    endfunction

    // one joint: adc conversion, clamped integrator, feedforward + pi voltage, duty
    function automatic void joint_duty(input int j, input logic [15:0] adc,
                                       input logic signed [15:0] speed,
                                       input logic signed [15:0] target,
                                       output logic [15:0] duty, output logic rev,
                                       output logic signed [15:0] sensed);
        longint meas, err, acc, volts, bound;
        longint unsigned mag;
        logic neg;
        // 15 - 30*adc/65536 amps in Q5.11, rounded half up; the offset keeps it positive
        meas  = ((longint'(1015816) - 15 * longint'(adc)) >>> 4) - 32768;
        err   = longint'(target) - meas;
        bound = longint'(integ_bound);
        acc   = longint'(integ[j]) + err;
        if (acc > bound)
            acc = bound;
        if (acc < -bound)
            acc = -bound;
        integ[j] = int'(acc);
        // everything lands in Q.19; kt*speed is Q.16 so it gets three more bits
        volts = longint'(res_ff) * longint'(target)
              + longint'(kt_ff) * longint'(speed) * 8
              + longint'(gain_p) * err
              + longint'(gain_i) * acc;
        neg = volts < 0;
        mag = neg ? longint'(-volts) : longint'(volts);
        mag = (mag * longint'(inv_vsup) + (64'd1 << 19)) >> 20;
        if (mag > longint'(duty_cap))
            mag = longint'(duty_cap);
        duty   = mag[15:0];
        // a zero scale or zero cap forces forward; a tiny negative duty still reverses
        rev    = neg && (inv_vsup != 16'd0) && (duty_cap != 16'd0);
        sensed = meas[15:0];
    endfunction

    function automatic dmpi_pkg::t_result predict_tick(input dmpi_pkg::t_item it);
        dmpi_pkg::t_result r;
        r = '0;
        // joints without integrator state report all zeros
        if (dmpi_pkg::ACTIVE >= 1)
            joint_duty(0, it.adc_a, it.speed_a, it.target_a,
                       r.duty_a, r.reverse_a, r.sensed_a);
        if (dmpi_pkg::ACTIVE >= 2)
            joint_duty(1, it.adc_b, it.speed_b, it.target_b,
                       r.duty_b, r.reverse_b, r.sensed_b);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_step mk_req(input logic [15:0] adc_a, adc_b, speed_a, speed_b,
                                     target_a, target_b);
        t_step s;
        s = '0;
        s.kind = STEP_REQ;
        s.item = '{adc_a: adc_a, adc_b: adc_b, speed_a: speed_a, speed_b: speed_b,
                   target_a: target_a, target_b: target_b};
        return s;
    endfunction

    // duty forced to zero and forward; only the measured currents carry information
    function automatic t_step mk_known(input logic [15:0] adc_a, adc_b, speed_a, speed_b,
                                       target_a, target_b, sensed_a, sensed_b);
        t_step s;
        s = mk_req(adc_a, adc_b, speed_a, speed_b, target_a, target_b);
        s.kind = STEP_REQ_KNOWN;
        s.known.sensed_a = sensed_a;
        s.known.sensed_b = sensed_b;
        return s;
    endfunction

    function automatic t_step mk_wr(input logic [2:0] idx, input logic [15:0] data);
        t_step s;
        s = '0;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.data = data;
        return s;
    endfunction

    // mostly near the operating point so the loop stays out of saturation, rest anything
    function automatic dmpi_pkg::t_item random_tick();
        dmpi_pkg::t_item it;
        if ($urandom_range(99) < 60) begin
            it.adc_a    = 16'(32768 + $urandom_range(0, 8191) - 4096);
            it.adc_b    = 16'(32768 + $urandom_range(0, 8191) - 4096);
            it.speed_a  = 16'($urandom_range(0, 8191) - 4096);
            it.speed_b  = 16'($urandom_range(0, 8191) - 4096);
            it.target_a = 16'($urandom_range(0, 16383) - 8192);
            it.target_b = 16'($urandom_range(0, 16383) - 8192);
        end else begin
            it = dmpi_pkg::t_item'({$urandom, $urandom, $urandom});
        end
        return it;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg(idx, data);
        n_writes++;
    endtask

    // present one request, hold it until taken, then record what it must produce
    task automatic send_req(input dmpi_pkg::t_item it, input logic use_known,
                            input dmpi_pkg::t_result known);
        dmpi_pkg::t_result r;
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        req_item   <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        r = predict_tick(it);  // always run so the integrators track
        tick_outcomes_q.push_back(use_known ? known : r);
        n_reqs++;
    endtask

    // drop valid, wait for every outstanding result, then let the sequencer go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tick_outcomes_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_phase_config(input int phase);
        logic [15:0] kp, ki, lim, cap, res, kt, inv;
        case (phase)
            0: begin  // defaults with full duty
                kp = 16'd1024; ki = 16'd102; lim = 16'd6144; cap = 16'd32768;
                res = 16'd512; kt = 16'd46; inv = 16'd5461;
            end
            1: begin  // anything goes
                kp = 16'($urandom); ki = 16'($urandom); lim = 16'($urandom);
                cap = 16'($urandom); res = 16'($urandom); kt = 16'($urandom);
                inv = 16'($urandom);
            end
            2: begin  // everything at the top, cap above full duty
                kp = 16'hFFFF; ki = 16'hFFFF; lim = 16'h7FFF; cap = 16'hFFFF;
                res = 16'hFFFF; kt = 16'hFFFF; inv = 16'hFFFF;
            end
            3: begin  // feedforward only, pi off
                kp = 16'd0; ki = 16'd0; lim = 16'd0; cap = 16'($urandom_range(1, 32768));
                res = 16'($urandom_range(0, 4096)); kt = 16'($urandom_range(0, 512));
                inv = 16'($urandom);
            end
            default: begin  // moderate random tuning
                kp = 16'($urandom_range(0, 4096)); ki = 16'($urandom_range(0, 1024));
                lim = 16'($urandom_range(0, 16384)); cap = 16'($urandom_range(0, 32768));
                res = 16'($urandom_range(0, 2048)); kt = 16'($urandom_range(0, 256));
                inv = 16'($urandom_range(1000, 20000));
            end
        endcase
        write_reg(dmpi_pkg::CFG_PROP_GAIN, kp);
        write_reg(dmpi_pkg::CFG_INTEGRAL_GAIN, ki);
        write_reg(dmpi_pkg::CFG_INTEG_LIMIT, lim);
        write_reg(dmpi_pkg::CFG_DUTY_LIMIT, cap);
        write_reg(dmpi_pkg::CFG_RESISTANCE, res);
        write_reg(dmpi_pkg::CFG_TORQUE_CONST, kt);
        write_reg(dmpi_pkg::CFG_INV_SUPPLY, inv);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------

    always @(posedge i_clk)
        i_out_ready <= calm || ($urandom_range(99) >= 31);

    task automatic check_field(input string what, input longint want, input longint seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        dmpi_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_outcomes_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual %p",
                         $time, got);
                n_errors++;
            end else begin
                want = tick_outcomes_q.pop_front();
                check_field("duty_a", want.duty_a, got.duty_a);
                check_field("reverse_a", want.reverse_a, got.reverse_a);
                check_field("duty_b", want.duty_b, got.duty_b);
                check_field("reverse_b", want.reverse_b, got.reverse_b);
                check_field("sensed_a", want.sensed_a, got.sensed_a);
                check_field("sensed_b", want.sensed_b, got.sensed_b);
                n_checked++;
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        logic last_was_req;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        req_item     = '0;
        i_out_ready  = 1'b0;
        calm         = 1'b0;
        n_errors     = 0;
        n_reqs       = 0;
        n_checked    = 0;
        n_writes     = 0;
        idle_count   = 0;
        last_was_req = 1'b0;

        // predictor starts from the reset register values
        gain_p = 16'd1024; gain_i = 16'd102; integ_bound = 15'd6144; duty_cap = 16'd0;
        res_ff = 16'd512; kt_ff = 16'd46; inv_vsup = 16'd5461;
        integ[0] = 0;
        integ[1] = 0;

        // after reset the duty cap is zero: duty 0, forward, only the adc conversion shows
        plan.push_back(mk_known(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                16'd30720, -16'sd30719));
        plan.push_back(mk_known(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'd0, 16'd0));
        plan.push_back(mk_known(16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'd10240, -16'sd10239));
        // full duty, default gains
        plan.push_back(mk_wr(dmpi_pkg::CFG_DUTY_LIMIT, 16'd32768));
        plan.push_back(mk_req(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        plan.push_back(mk_req(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        plan.push_back(mk_req(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        // every register at its top; cap above full duty is used as given
        plan.push_back(mk_wr(dmpi_pkg::CFG_PROP_GAIN, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INTEGRAL_GAIN, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INTEG_LIMIT, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_DUTY_LIMIT, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_RESISTANCE, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_TORQUE_CONST, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INV_SUPPLY, 16'hFFFF));
        plan.push_back(mk_req(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        plan.push_back(mk_req(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        plan.push_back(mk_req(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        plan.push_back(mk_req(16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
        // integrators are wound up; shrinking the bound clamps them on the next tick
        plan.push_back(mk_wr(dmpi_pkg::CFG_INTEG_LIMIT, 16'd100));
        plan.push_back(mk_req(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INTEG_LIMIT, 16'd0));
        plan.push_back(mk_req(16'h7FFF, 16'h8001, 16'h0100, 16'hFF00, 16'h0800, 16'hF800));
        // zero inverse supply: negative voltage still drives forward at zero duty
        plan.push_back(mk_wr(dmpi_pkg::CFG_INV_SUPPLY, 16'd0));
        plan.push_back(mk_known(16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'd30720, -16'sd30719));
        // tiny negative voltage rounds to zero duty yet reports reverse
        plan.push_back(mk_wr(dmpi_pkg::CFG_PROP_GAIN, 16'd0));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INTEGRAL_GAIN, 16'd0));
        plan.push_back(mk_wr(dmpi_pkg::CFG_TORQUE_CONST, 16'd0));
        plan.push_back(mk_wr(dmpi_pkg::CFG_RESISTANCE, 16'd1));
        plan.push_back(mk_wr(dmpi_pkg::CFG_INV_SUPPLY, 16'd1));
        plan.push_back(mk_wr(dmpi_pkg::CFG_DUTY_LIMIT, 16'd32768));
        plan.push_back(mk_req(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001));
        plan.push_back(mk_req(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
        // write to a non-existent register must change nothing
        plan.push_back(mk_wr(CFG_UNUSED_IDX, 16'hFFFF));
        plan.push_back(mk_req(16'h4000, 16'hC000, 16'h1234, 16'hEDCC, 16'hFFFF, 16'h0001));
        // cap of one lsb
        plan.push_back(mk_wr(dmpi_pkg::CFG_INV_SUPPLY, 16'hFFFF));
        plan.push_back(mk_wr(dmpi_pkg::CFG_DUTY_LIMIT, 16'd1));
        plan.push_back(mk_req(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk
        foreach (plan[k]) begin
            if (plan[k].kind == STEP_CFG) begin
                if (last_was_req)
                    settle();
                write_reg(plan[k].idx, plan[k].data);
                last_was_req = 1'b0;
            end else begin
                send_req(plan[k].item, plan[k].kind == STEP_REQ_KNOWN, plan[k].known);
                last_was_req = 1'b1;
            end
        end

        // random phases, each under its own register setting; phase 3 runs with no idling
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            write_phase_config(phase);
            calm = (phase == 3);
            repeat (PHASE_REQS) send_req(random_tick(), 1'b0, '0);
        end
        calm = 1'b0;
        settle();

        $display("%0d requests, %0d results compared, %0d register writes over %0d phases",
                 n_reqs, n_checked, n_writes, PHASES);
        $display("covered reset values, zero and oversized duty caps, integrator clamp, "
                 , "zero supply scale, sub-lsb reverse and an unknown register");
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dmpi_pkg.sv
design/dmpi_ctrl.sv
design/dmpi_dp.sv
design/dual_motor_pi_current_loop.sv
verif/tb_dual_motor_pi_current_loop.sv
